/* design/ictl_pkg.sv */
// Shared types and constants for the idle connection timeout list.
package ictl_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;
  localparam int LIMIT_W     = 20;
  localparam int TIME_W      = 32;
  localparam int SLOT_W      = 4;

  typedef enum logic [1:0] {
    ACT_CONNECT    = 2'd0,
    ACT_DISCONNECT = 2'd1,
    ACT_MESSAGE    = 2'd2,
    ACT_TICK       = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [SLOT_W-1:0]   conn_slot;
    logic [TIME_W-1:0]   time_now;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] close_slot;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNLINK,
    ST_APPEND_A,
    ST_APPEND_B,
    ST_WALK_RD,
    ST_WALK_EVAL,
    ST_WALK_FIN
  } state_t;

endpackage

/* design/idle_connection_timeout_list_unit.sv */
// Idle connection timeout list: LRU list of connection slots in link and stamp memories.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_data (action, conn_slot, time_now)
//   out      output     out_valid/out_stall out_data (close_slot, last)
//   cfg      input      cfg_valid/cfg_ready cfg_data (idle_limit)
//
// A connect or message to a listed slot passes through accept, unlink and two append
// writes; other events take a subset of these steps. A tick is accepted, then reads
// link/stamp memory and evaluates for each slot visited, enters the read state again
// when the walk runs off the list end, and then finishes; it can wait while the output stalls.
// Reset clears the listed bits, head and tail at once.
// The output register lets a result wait while the next item is accepted.
module idle_connection_timeout_list_unit #(
  parameter int MAX_CONN = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ictl_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ictl_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ictl_pkg::LIMIT_W-1:0]        cfg_data
);

  localparam int LW = $clog2(MAX_CONN + 1);
  localparam int SW = (MAX_CONN > 1) ? $clog2(MAX_CONN) : 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_CONN);

  ictl_pkg::state_t state, state_next;

  // Link and stamp memories.
  logic [LW-1:0]               next_mem  [MAX_CONN];
  logic [LW-1:0]               prev_mem  [MAX_CONN];
  logic [ictl_pkg::TIME_W-1:0] stamp_mem [MAX_CONN];

  logic                        rd_en;
  logic [SW-1:0]               rd_addr;
  logic [LW-1:0]               next_rd;
  logic [LW-1:0]               prev_rd;
  logic [ictl_pkg::TIME_W-1:0] stamp_rd;

  logic                        nx_we;
  logic [SW-1:0]               nx_waddr;
  logic [LW-1:0]               nx_wdata;
  logic                        pv_we;
  logic [SW-1:0]               pv_waddr;
  logic [LW-1:0]               pv_wdata;
  logic                        st_we;
  logic [SW-1:0]               st_waddr;
  logic [ictl_pkg::TIME_W-1:0] st_wdata;

  // Control and datapath registers.
  logic [MAX_CONN-1:0]          listed, listed_next;
  logic [LW-1:0]                head_slot, head_slot_next;
  logic [LW-1:0]                tail_slot, tail_slot_next;
  logic [ictl_pkg::LIMIT_W-1:0] idle_limit;
  ictl_pkg::action_t            act, act_next;
  logic [SW-1:0]                slot, slot_next;
  logic [ictl_pkg::TIME_W-1:0]  now, now_next;
  logic [LW-1:0]                cur, cur_next;
  logic [LW-1:0]                steps, steps_next;
  logic [ictl_pkg::CNT_W-1:0]   count, count_next;
  logic                         pend_valid, pend_valid_next;
  logic [ictl_pkg::SLOT_W-1:0]  pend_slot, pend_slot_next;

  logic                         out_load;
  ictl_pkg::out_item_t          out_load_data;
  logic                         out_free;

  logic                         in_accept;
  logic                         in_slot_ok;
  logic [SW-1:0]                in_slot;
  logic                         in_listed;
  logic [ictl_pkg::TIME_W-1:0]  age;
  logic                         age_neg;
  logic                         age_over;
  logic                         count_full;
  logic                         walk_done;

  assign in_stall   = (state != ictl_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign in_slot    = SW'(in_data.conn_slot);
  assign in_slot_ok = int'(in_data.conn_slot) < MAX_CONN;
  assign in_listed  = listed[in_slot];
  assign out_free   = !out_valid || !out_stall;

  assign age        = now - stamp_rd;
  assign age_neg    = age[ictl_pkg::TIME_W-1];
  assign age_over   = !age_neg && (age > ictl_pkg::TIME_W'(idle_limit));
  assign count_full = (count + ictl_pkg::CNT_W'(1)) == ictl_pkg::CNT_W'(ictl_pkg::MAX_RESULTS);
  assign walk_done  = (cur >= NULL_LINK) || (steps == NULL_LINK);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ictl_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_data.action == ictl_pkg::ACT_TICK) begin
            state_next = ictl_pkg::ST_WALK_RD;
          end else if (in_slot_ok) begin
            if (in_listed) begin
              state_next = ictl_pkg::ST_UNLINK;
            end else if (in_data.action == ictl_pkg::ACT_CONNECT) begin
              state_next = ictl_pkg::ST_APPEND_A;
            end
          end
        end
      end
      ictl_pkg::ST_UNLINK: begin
        state_next = (act == ictl_pkg::ACT_DISCONNECT) ? ictl_pkg::ST_IDLE
                                                       : ictl_pkg::ST_APPEND_A;
      end
      ictl_pkg::ST_APPEND_A: state_next = ictl_pkg::ST_APPEND_B;
      ictl_pkg::ST_APPEND_B: state_next = ictl_pkg::ST_IDLE;
      ictl_pkg::ST_WALK_RD: begin
        state_next = walk_done ? ictl_pkg::ST_WALK_FIN : ictl_pkg::ST_WALK_EVAL;
      end
      ictl_pkg::ST_WALK_EVAL: begin
        if (age_over) begin
          if (!pend_valid || out_free) begin
            state_next = count_full ? ictl_pkg::ST_WALK_FIN : ictl_pkg::ST_WALK_RD;
          end
        end else if (age_neg) begin
          state_next = ictl_pkg::ST_WALK_RD;
        end else begin
          state_next = ictl_pkg::ST_WALK_FIN;
        end
      end
      ictl_pkg::ST_WALK_FIN: begin
        if (!pend_valid || out_free) begin
          state_next = ictl_pkg::ST_IDLE;
        end
      end
      default: state_next = ictl_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and register updates.
  always_comb begin
    rd_en           = 1'b0;
    rd_addr         = cur[SW-1:0];
    nx_we           = 1'b0;
    nx_waddr        = slot;
    nx_wdata        = NULL_LINK;
    pv_we           = 1'b0;
    pv_waddr        = slot;
    pv_wdata        = tail_slot;
    st_we           = 1'b0;
    st_waddr        = cur[SW-1:0];
    st_wdata        = now;
    listed_next     = listed;
    head_slot_next  = head_slot;
    tail_slot_next  = tail_slot;
    act_next        = act;
    slot_next       = slot;
    now_next        = now;
    cur_next        = cur;
    steps_next      = steps;
    count_next      = count;
    pend_valid_next = pend_valid;
    pend_slot_next  = pend_slot;
    out_load        = 1'b0;
    out_load_data   = '{close_slot: pend_slot, last: 1'b0};
    case (state)
      ictl_pkg::ST_IDLE: begin
        if (in_accept) begin
          act_next   = in_data.action;
          slot_next  = in_slot;
          now_next   = in_data.time_now;
          cur_next   = head_slot;
          steps_next = '0;
          count_next = '0;
          // Fetch the slot's links now so the unlink has them next cycle.
          rd_en      = 1'b1;
          rd_addr    = in_slot;
          if (in_data.action != ictl_pkg::ACT_TICK && in_slot_ok) begin
            st_waddr = in_slot;
            st_wdata = in_data.time_now;
            st_we    = (in_data.action == ictl_pkg::ACT_CONNECT) ||
                       (in_data.action == ictl_pkg::ACT_MESSAGE && in_listed);
          end
        end
      end
      ictl_pkg::ST_UNLINK: begin
        if (prev_rd >= NULL_LINK) begin
          head_slot_next = next_rd;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = prev_rd[SW-1:0];
          nx_wdata = next_rd;
        end
        if (next_rd >= NULL_LINK) begin
          tail_slot_next = prev_rd;
        end else begin
          pv_we    = 1'b1;
          pv_waddr = next_rd[SW-1:0];
          pv_wdata = prev_rd;
        end
        listed_next[slot] = 1'b0;
      end
      ictl_pkg::ST_APPEND_A: begin
        pv_we    = 1'b1;
        pv_waddr = slot;
        pv_wdata = tail_slot;
        nx_we    = 1'b1;
        nx_waddr = slot;
        nx_wdata = NULL_LINK;
      end
      ictl_pkg::ST_APPEND_B: begin
        if (tail_slot >= NULL_LINK) begin
          head_slot_next = LW'(slot);
        end else begin
          nx_we    = 1'b1;
          nx_waddr = tail_slot[SW-1:0];
          nx_wdata = LW'(slot);
        end
        tail_slot_next    = LW'(slot);
        listed_next[slot] = 1'b1;
      end
      ictl_pkg::ST_WALK_RD: begin
        if (!walk_done) begin
          rd_en   = 1'b1;
          rd_addr = cur[SW-1:0];
        end
      end
      ictl_pkg::ST_WALK_EVAL: begin
        if (age_over) begin
          // The previous close is sent once a later one proves it is not the last.
          if (!pend_valid || out_free) begin
            out_load        = pend_valid;
            pend_valid_next = 1'b1;
            pend_slot_next  = ictl_pkg::SLOT_W'(cur);
            count_next      = count + ictl_pkg::CNT_W'(1);
            cur_next        = next_rd;
            steps_next      = steps + LW'(1);
          end
        end else if (age_neg) begin
          // Clock went backward: restamp and keep walking.
          st_we      = 1'b1;
          st_waddr   = cur[SW-1:0];
          st_wdata   = now;
          cur_next   = next_rd;
          steps_next = steps + LW'(1);
        end
      end
      ictl_pkg::ST_WALK_FIN: begin
        if (pend_valid && out_free) begin
          out_load        = 1'b1;
          out_load_data   = '{close_slot: pend_slot, last: 1'b1};
          pend_valid_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ictl_pkg::ST_IDLE;
      listed     <= '0;
      head_slot  <= NULL_LINK;
      tail_slot  <= NULL_LINK;
      idle_limit <= ictl_pkg::LIMIT_W'(10);
      pend_valid <= 1'b0;
      count      <= '0;
      steps      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      listed     <= listed_next;
      head_slot  <= head_slot_next;
      tail_slot  <= tail_slot_next;
      pend_valid <= pend_valid_next;
      count      <= count_next;
      steps      <= steps_next;
      if (cfg_valid && cfg_ready) begin
        idle_limit <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    act       <= act_next;
    slot      <= slot_next;
    now       <= now_next;
    cur       <= cur_next;
    pend_slot <= pend_slot_next;
    if (out_load) begin
      out_data <= out_load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_waddr] <= nx_wdata;
    end
    if (rd_en) begin
      next_rd <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      prev_mem[pv_waddr] <= pv_wdata;
    end
    if (rd_en) begin
      prev_rd <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stamp_mem[st_waddr] <= st_wdata;
    end
    if (rd_en) begin
      stamp_rd <= stamp_mem[rd_addr];
    end
  end

`ifndef ASSERT_OFF
  a_head_tail_null: assert property (@(posedge clk) disable iff (rst)
    (state == ictl_pkg::ST_IDLE) |-> ((head_slot >= NULL_LINK) == (tail_slot >= NULL_LINK)))
    else $error("head and tail disagree on an empty list");

  a_empty_list: assert property (@(posedge clk) disable iff (rst)
    (state == ictl_pkg::ST_IDLE) |-> ((listed == '0) == (head_slot >= NULL_LINK)))
    else $error("listed bits disagree with the head pointer");

  a_no_pending_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ictl_pkg::ST_IDLE) |-> !pend_valid)
    else $error("close request left pending after a tick");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ictl_pkg::CNT_W'(ictl_pkg::MAX_RESULTS))
    else $error("too many close requests in one tick");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ictl_pkg::ST_WALK_EVAL) |-> (steps < NULL_LINK && cur < NULL_LINK))
    else $error("walk evaluated past the list end");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the idle connection timeout list with a built-in list predictor.
module tb_top;

  localparam int NSLOT = 16;
  localparam logic [4:0] NIL = 5'd16;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ictl_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ictl_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ictl_pkg::LIMIT_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  idle_connection_timeout_list_unit #(.MAX_CONN(NSLOT)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Predicted list state.
  logic [4:0] link_next[NSLOT];
  logic [4:0] link_prev[NSLOT];
  logic [ictl_pkg::TIME_W-1:0] slot_stamp[NSLOT];
  bit slot_listed[NSLOT];
  logic [4:0] list_head;
  logic [4:0] list_tail;
  logic [ictl_pkg::LIMIT_W-1:0] idle_limit;

  ictl_pkg::out_item_t pending_closes[$];
  int mismatch_count = 0;
  int total_closes = 0;
  int burst_left = 0;
  logic [ictl_pkg::TIME_W-1:0] wall = '0;

  function automatic logic [ictl_pkg::SLOT_W-1:0] ix(logic [4:0] v);
    return v[ictl_pkg::SLOT_W-1:0];
  endfunction

  function automatic void clear_list();
    slot_listed = '{default: 1'b0};
    link_next = '{default: NIL};
    link_prev = '{default: NIL};
    slot_stamp = '{default: '0};
    list_head = NIL;
    list_tail = NIL;
    idle_limit = 20'd10;
  endfunction

  function automatic void drop_slot(logic [4:0] s);
    logic [4:0] p;
    logic [4:0] n;
    p = link_prev[ix(s)];
    n = link_next[ix(s)];
    if (p == NIL) begin
      list_head = n;
    end else begin
      link_next[ix(p)] = n;
    end
    if (n == NIL) begin
      list_tail = p;
    end else begin
      link_prev[ix(n)] = p;
    end
    slot_listed[ix(s)] = 1'b0;
  endfunction

  function automatic void push_slot(logic [4:0] s);
    link_prev[ix(s)] = list_tail;
    link_next[ix(s)] = NIL;
    if (list_tail == NIL) begin
      list_head = s;
    end else begin
      link_next[ix(list_tail)] = s;
    end
    list_tail = s;
    slot_listed[ix(s)] = 1'b1;
  endfunction

  // Updates the list for one event and queues the close requests of a tick.
  // Returns 0 only for a disconnect or message to an unlisted slot.
  function automatic bit apply_event(ictl_pkg::in_item_t it);
    logic [4:0] s;
    logic [4:0] cur;
    logic [ictl_pkg::TIME_W-1:0] age;
    ictl_pkg::out_item_t res;
    int found;
    int steps;
    s = {1'b0, it.conn_slot};
    found = 0;
    case (it.action)
      ictl_pkg::ACT_CONNECT: begin
        if (slot_listed[ix(s)]) drop_slot(s);
        slot_stamp[ix(s)] = it.time_now;
        push_slot(s);
        return 1'b1;
      end
      ictl_pkg::ACT_DISCONNECT: begin
        if (!slot_listed[ix(s)]) return 1'b0;
        drop_slot(s);
        return 1'b1;
      end
      ictl_pkg::ACT_MESSAGE: begin
        if (!slot_listed[ix(s)]) return 1'b0;
        slot_stamp[ix(s)] = it.time_now;
        drop_slot(s);
        push_slot(s);
        return 1'b1;
      end
      default: begin
        cur = list_head;
        steps = 0;
        while (steps < NSLOT && cur != NIL) begin
          age = it.time_now - slot_stamp[ix(cur)];
          if (!age[ictl_pkg::TIME_W-1] && age > idle_limit) begin
            res.close_slot = ix(cur);
            res.last = 1'b0;
            pending_closes = {pending_closes, res};
            found++;
            if (found >= ictl_pkg::MAX_RESULTS) break;
          end else if (age[ictl_pkg::TIME_W-1]) begin
            // A clock that went backwards restamps the slot and keeps walking.
            slot_stamp[ix(cur)] = it.time_now;
          end else begin
            break;
          end
          cur = link_next[ix(cur)];
          steps++;
        end
        if (found > 0) pending_closes[pending_closes.size()-1].last = 1'b1;
        total_closes += found;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic ictl_pkg::in_item_t mk(ictl_pkg::action_t a, int s,
                                            logic [ictl_pkg::TIME_W-1:0] t);
    ictl_pkg::in_item_t it;
    it.action = a;
    it.conn_slot = s[ictl_pkg::SLOT_W-1:0];
    it.time_now = t;
    return it;
  endfunction

  // Sends one event in bursts with random gaps; returns the flag from apply_event.
  task automatic send_event(input ictl_pkg::in_item_t it, output bit effective);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    effective = apply_event(it);
    burst_left--;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_closes.size() != 0) @(posedge clk);
    // A tick with nothing to close may still be walking the list.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [ictl_pkg::LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    idle_limit = value;
  endtask

  task automatic test_basic_events();
    bit eff;
    send_event(mk(ictl_pkg::ACT_TICK, 0, 32'd0), eff);
    send_event(mk(ictl_pkg::ACT_CONNECT, 0, 32'd0), eff);
    send_event(mk(ictl_pkg::ACT_CONNECT, 15, 32'd5), eff);
    send_event(mk(ictl_pkg::ACT_CONNECT, 7, 32'hFFFF_FFFF), eff);
    send_event(mk(ictl_pkg::ACT_MESSAGE, 3, 32'd1), eff);
    send_event(mk(ictl_pkg::ACT_DISCONNECT, 9, 32'd2), eff);
    send_event(mk(ictl_pkg::ACT_TICK, 0, 32'd11), eff);
    send_event(mk(ictl_pkg::ACT_CONNECT, 0, 32'd20), eff);
    send_event(mk(ictl_pkg::ACT_TICK, 0, 32'd16), eff);
    send_event(mk(ictl_pkg::ACT_MESSAGE, 15, 32'd30), eff);
    send_event(mk(ictl_pkg::ACT_DISCONNECT, 7, 32'd31), eff);
    send_event(mk(ictl_pkg::ACT_TICK, 0, 32'h8000_0010), eff);
    send_event(mk(ictl_pkg::ACT_TICK, 0, 32'h8000_0011), eff);
    wait_quiet();
  endtask

  // Every slot stale at once, so one tick emits the most close requests.
  task automatic test_full_list();
    bit eff;
    for (int i = 0; i < NSLOT; i++) begin
      send_event(mk(ictl_pkg::ACT_CONNECT, i, 32'd100 + i), eff);
    end
    send_event(mk(ictl_pkg::ACT_TICK, 0, 32'h0000_1000), eff);
    wait_quiet();
  endtask

  function automatic int pick_slot();
    int s;
    s = $urandom_range(0, NSLOT - 1);
    for (int i = 0; i < 4; i++) begin
      if (slot_listed[ictl_pkg::SLOT_W'(s)]) break;
      s = $urandom_range(0, NSLOT - 1);
    end
    return s;
  endfunction

  task automatic test_random_traffic();
    logic [ictl_pkg::LIMIT_W-1:0] limits[5];
    ictl_pkg::in_item_t it;
    bit eff;
    int n;
    int closes_before;
    int span;
    int roll;
    limits[0] = '0;
    limits[1] = 20'hFFFFF;
    limits[2] = 20'd10;
    limits[3] = ictl_pkg::LIMIT_W'($urandom_range(1, 64));
    limits[4] = ictl_pkg::LIMIT_W'($urandom_range(0, 20'hFFFFF));
    for (int p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      span = int'(limits[p]) / 3 + 4;
      n = 0;
      closes_before = total_closes;
      while (n < 40 || (total_closes - closes_before < 10 && n < 60)) begin
        roll = $urandom_range(0, 31);
        if (roll == 0) begin
          wall = $urandom();
        end else if (roll < 3) begin
          wall = wall - $urandom_range(1, 2 * span);
        end else begin
          wall = wall + $urandom_range(0, span);
        end
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          it = mk(ictl_pkg::ACT_CONNECT, $urandom_range(0, NSLOT - 1), wall);
        end else if (roll < 55) begin
          it = mk(ictl_pkg::ACT_MESSAGE, pick_slot(), wall);
        end else if (roll < 70) begin
          it = mk(ictl_pkg::ACT_DISCONNECT, pick_slot(), wall);
        end else begin
          it = mk(ictl_pkg::ACT_TICK, $urandom_range(0, NSLOT - 1), wall);
        end
        send_event(it, eff);
        if (eff) n++;
      end
      wait_quiet();
    end
  endtask

  // Receiver stall pattern: modes of no stalls, occasional bursts, frequent bursts and jitter.
  int stall_run = 0;
  int stall_mode = 0;
  int mode_cycles = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_cycles = $urandom_range(20, 120);
      end
      mode_cycles--;
      if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else if ((stall_mode == 1 && $urandom_range(0, 3) == 0) ||
                   (stall_mode == 2 && $urandom_range(0, 1) == 0)) begin
        stall_run = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else if (stall_mode == 3) begin
        out_stall <= 1'($urandom_range(0, 1));
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, ictl_pkg::out_item_t want,
                                 ictl_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected slot %0d last %0b, got slot %0d last %0b", what,
               want.close_slot, want.last, got.close_slot, got.last);
    end
  endtask

  always @(posedge clk) begin
    ictl_pkg::out_item_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_closes.size() == 0) begin
        report_mismatch("unexpected close transaction", '0, out_data);
      end else begin
        want = pending_closes.pop_front();
        if (out_data.close_slot !== want.close_slot || out_data.last !== want.last) begin
          report_mismatch("close transaction mismatch", want, out_data);
        end
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    clear_list();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_events();
    test_full_list();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
